### sv/cht_pkg.sv
// Shared types and constants for the chained hash table.
package cht_pkg;

    // Table geometry.
    localparam int BUCKETS    = 16;
    localparam int POOL_NODES = 64;

    // Field widths.
    localparam int KEY_W    = 31;
    localparam int BC_W     = 5;
    localparam int STATUS_W = 2;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int NODE_W   = $clog2(POOL_NODES);
    localparam int CNT_W    = $clog2(POOL_NODES + 1);

    // Bucket count after reset.
    localparam logic [BC_W-1:0] BUCKET_COUNT_RESET = BC_W'(13);

    // Operation codes carried on the input tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Result codes carried on the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_POOL_FULL = 2'd3
    } status_t;

    // One node of the pool.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              has_next;
        logic [NODE_W-1:0] next;
    } node_t;

    // Request to and answer from the modulo unit.
    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  key;
        logic [BC_W-1:0]   modulus;
    } mod_req_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] rem;
    } mod_rsp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH_GO,
        ST_HASH_WAIT,
        ST_INS_LINK,
        ST_SRCH_HEAD,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_RESP
    } state_t;

endpackage

### sv/cht_mod_unit.sv
// Bit-serial restoring modulo unit: key modulo a small modulus, one key bit per cycle.
module cht_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  cht_pkg::mod_req_t req,
    output cht_pkg::mod_rsp_t rsp
);
    import cht_pkg::*;

    localparam int STEP_W = $clog2(KEY_W);

    logic [BC_W-1:0]   rem_reg,  rem_next;
    logic [KEY_W-1:0]  key_reg,  key_next;
    logic [BC_W-1:0]   mod_reg,  mod_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BC_W:0]     trial;
    logic [BC_W:0]     diff;

    // One restoring step: bring in the next key bit and subtract if it fits.
    assign trial = {rem_reg, key_reg[KEY_W-1]};
    assign diff  = trial - {1'b0, mod_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        key_next  = key_reg;
        mod_next  = mod_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            key_next  = req.key;
            mod_next  = req.modulus;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            key_next = {key_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, mod_reg})
            begin
                rem_next = diff[BC_W-1:0];
            end
            else
            begin
                rem_next = trial[BC_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(KEY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        key_reg <= key_next;
        mod_reg <= mod_next;
    end

    // The remainder is below the modulus, which is at most the bucket count.
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[BUCKET_W-1:0];

endmodule

### sv/cht_node_ram.sv
// Node pool memory: one write port and one registered read port.
module cht_node_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [cht_pkg::NODE_W-1:0] wr_addr,
    input  cht_pkg::node_t            wr_data,
    input  logic [cht_pkg::NODE_W-1:0] rd_addr,
    output cht_pkg::node_t            rd_data
);
    import cht_pkg::*;

    node_t mem [POOL_NODES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/chained_hash_table.sv
// Top level of the chained hash table: sequencer, bucket table and output register.
//
// Use: each input beat on the s_ channel carries one operation, insert or search, in
// s_tuser and a 31-bit key in s_tdata. Every beat gives exactly one output beat on the
// m_ channel with a status in m_tuser and, for a successful search, the key in m_tdata.
// The bucket is the key modulo bucket_count, which the user writes over the cfg_ channel
// only while idle (the block itself does not enforce this); zero acts as one and values
// above the bucket count built saturate. A pool-full insert goes straight from acceptance
// to the response state. Otherwise the bit-serial modulo unit hashes the key first, then
// each chain node visited costs an address state and an evaluate state (address, then
// registered read of the node memory); the nodes walked are at most the pool size. One
// item is in work at a time: s_tready is high only while the sequencer is idle.
// The finished result sits in an output register; a new beat is accepted while it waits,
// and the next result is held back until m_tready has taken the earlier one.
// Reset empties every bucket, frees the whole pool and sets bucket_count to 13; it takes
// effect at once with no clearing pass, since node contents are only read once written.
module chained_hash_table (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,  // [30:0] key, [31] zero
    input  logic                        s_tuser,  // [0] kind
    // Output stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // [30:0] found_key, [31] zero
    output logic [cht_pkg::STATUS_W-1:0] m_tuser, // [1:0] status
    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cht_pkg::BC_W-1:0]    cfg_data  // bucket_count
);
    import cht_pkg::*;

    state_t state_reg, state_next;

    logic [BC_W-1:0]     bc_reg,     bc_next;
    logic                kind_reg,   kind_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [NODE_W-1:0]   cur_reg,    cur_next;
    logic [NODE_W-1:0]   new_reg,    new_next;
    logic [CNT_W-1:0]    alloc_reg,  alloc_next;
    status_t             res_reg,    res_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [KEY_W-1:0]    out_key_reg,    out_key_next;

    logic [BUCKETS-1:0]  used_reg;
    logic [NODE_W-1:0]   head_reg [BUCKETS];
    logic                head_we;

    logic [BC_W-1:0]     modulus;
    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;

    logic                ram_we;
    logic [NODE_W-1:0]   ram_waddr;
    node_t               ram_wdata;
    node_t               ram_rdata;

    logic                in_beat;
    logic                out_free;
    logic                pool_full;
    logic                head_taken;
    logic                tail_found;

    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign pool_full = alloc_reg >= CNT_W'(POOL_NODES);
    // A new head is needed when the bucket is empty or its head is not older than the new node.
    assign head_taken = used_reg[bucket_reg] && ({1'b0, head_reg[bucket_reg]} < {1'b0, new_reg});
    assign tail_found = !ram_rdata.has_next || (ram_rdata.next >= new_reg);

    // Saturate the bucket count into the range of buckets built.
    always_comb
    begin
        if (bc_reg == '0)
        begin
            modulus = BC_W'(1);
        end
        else if (bc_reg > BC_W'(BUCKETS))
        begin
            modulus = BC_W'(BUCKETS);
        end
        else
        begin
            modulus = bc_reg;
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser == KIND_INSERT && pool_full)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_HASH_GO;
                    end
                end
            end
            ST_HASH_GO:
            begin
                state_next = ST_HASH_WAIT;
            end
            ST_HASH_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = (kind_reg == KIND_INSERT) ? ST_INS_LINK : ST_SRCH_HEAD;
                end
            end
            ST_INS_LINK:
            begin
                state_next = head_taken ? ST_WALK_RD : ST_RESP;
            end
            ST_SRCH_HEAD:
            begin
                state_next = used_reg[bucket_reg] ? ST_WALK_RD : ST_RESP;
            end
            ST_WALK_RD:
            begin
                if (kind_reg == KIND_SEARCH && {1'b0, cur_reg} >= alloc_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_WALK_EV;
                end
            end
            ST_WALK_EV:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    state_next = tail_found ? ST_RESP : ST_WALK_RD;
                end
                else if (ram_rdata.key == key_reg || !ram_rdata.has_next)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic of the sequencer.
    always_comb
    begin
        bc_next         = bc_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        bucket_next     = bucket_reg;
        cur_next        = cur_reg;
        new_next        = new_reg;
        alloc_next      = alloc_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        head_we         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = new_reg;
        ram_wdata       = '{key: key_reg, has_next: 1'b0, next: '0};
        mod_req         = '{start: 1'b0, key: key_reg, modulus: modulus};

        if (cfg_valid && cfg_ready)
        begin
            bc_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    kind_next = s_tuser;
                    key_next  = s_tdata[KEY_W-1:0];
                    res_next  = STATUS_POOL_FULL;
                end
            end
            ST_HASH_GO:
            begin
                mod_req.start = 1'b1;
            end
            ST_HASH_WAIT:
            begin
                bucket_next = mod_rsp.rem;
                new_next    = alloc_reg[NODE_W-1:0];
            end
            ST_INS_LINK:
            begin
                // Store the new node and either make it the head or walk to the tail.
                ram_we     = 1'b1;
                alloc_next = alloc_reg + 1'b1;
                res_next   = STATUS_INSERTED;
                cur_next   = head_reg[bucket_reg];
                head_we    = !head_taken;
            end
            ST_SRCH_HEAD:
            begin
                res_next = STATUS_NOT_FOUND;
                cur_next = head_reg[bucket_reg];
            end
            ST_WALK_RD:
            begin
                // The node address goes to the memory in this cycle.
            end
            ST_WALK_EV:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (tail_found)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_reg;
                        ram_wdata = '{key: ram_rdata.key, has_next: 1'b1, next: new_reg};
                    end
                    else
                    begin
                        cur_next = ram_rdata.next;
                    end
                end
                else if (ram_rdata.key == key_reg)
                begin
                    res_next = STATUS_FOUND;
                end
                else
                begin
                    cur_next = ram_rdata.next;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_key_next    = (res_reg == STATUS_FOUND) ? key_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= BUCKET_COUNT_RESET;
            alloc_reg     <= '0;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
            if (head_we)
            begin
                used_reg[bucket_reg] <= 1'b1;
            end
        end
    end

    // Payload registers and bucket heads.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        bucket_reg     <= bucket_next;
        cur_reg        <= cur_next;
        new_reg        <= new_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        if (head_we)
        begin
            head_reg[bucket_reg] <= new_reg;
        end
    end

    cht_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    cht_node_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (cur_reg),
        .rd_data (ram_rdata)
    );

    // Port drive.
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {1'b0, out_key_reg};

endmodule

### tb/chained_hash_table_tb.sv
// Self-checking testbench for the chained hash table: stream stimulus, table prediction and result checks.
module chained_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cht_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASE_BEATS = 145;

    // One expected answer per accepted beat.
    typedef struct {
        logic             kind;
        logic [KEY_W-1:0] key;
        status_t          status;
        logic [KEY_W-1:0] found_key;
    } answer_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // [30:0] key, [31] zero
    logic                s_tuser;   // [0] kind
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;   // [30:0] found_key, [31] zero
    logic [STATUS_W-1:0] m_tuser;   // [1:0] status
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BC_W-1:0]     cfg_data;  // bucket_count

    // Predicted table contents.
    logic [BC_W-1:0]   bucket_count;
    bit                bucket_used [BUCKETS];
    logic [NODE_W-1:0] bucket_head [BUCKETS];
    logic [KEY_W-1:0]  node_key [POOL_NODES];
    bit                node_has_next [POOL_NODES];
    logic [NODE_W-1:0] node_next [POOL_NODES];
    int unsigned       nodes_used;

    answer_t           pending_answers[$];
    logic [KEY_W-1:0]  stored_keys[$];

    int  errors;
    int  beats_sent;
    int  cfg_writes;
    int  status_seen [4];
    bit  sender_idles;
    int  burst_left;
    bit  long_hold_req;

    chained_hash_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #(10_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // Effective modulus: zero acts as one, values above the table size saturate.
    function automatic int unsigned hash_modulus();
        int unsigned m;
        m = bucket_count;
        if (m == 0)
            m = 1;
        if (m > BUCKETS)
            m = BUCKETS;
        return m;
    endfunction

    function automatic int unsigned bucket_for(input logic [KEY_W-1:0] key);
        return key % hash_modulus();
    endfunction

    // Append a node at the tail of its bucket's chain, unless the pool is exhausted.
    function automatic status_t table_insert(input logic [KEY_W-1:0] key);
        int unsigned b;
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] cur;
        if (nodes_used >= POOL_NODES)
            return STATUS_POOL_FULL;
        n = NODE_W'(nodes_used);
        node_key[n] = key;
        node_has_next[n] = 1'b0;
        node_next[n] = '0;
        nodes_used = nodes_used + 1;
        b = bucket_for(key);
        if (!bucket_used[b] || bucket_head[b] >= n)
        begin
            bucket_used[b] = 1'b1;
            bucket_head[b] = n;
            return STATUS_INSERTED;
        end
        cur = bucket_head[b];
        for (int steps = 0; steps < POOL_NODES; steps++)
        begin
            if (!node_has_next[cur] || node_next[cur] >= n)
                break;
            cur = node_next[cur];
        end
        node_has_next[cur] = 1'b1;
        node_next[cur] = n;
        return STATUS_INSERTED;
    endfunction

    // Walk the chain from the head of the key's bucket looking for a match.
    function automatic bit table_lookup(input logic [KEY_W-1:0] key);
        int unsigned b;
        int unsigned cur;
        b = bucket_for(key);
        if (!bucket_used[b])
            return 1'b0;
        cur = bucket_head[b];
        for (int steps = 0; steps < POOL_NODES; steps++)
        begin
            if (cur >= nodes_used)
                return 1'b0;
            if (node_key[cur] == key)
                return 1'b1;
            if (!node_has_next[cur])
                return 1'b0;
            cur = node_next[cur];
        end
        return 1'b0;
    endfunction

    function automatic answer_t predict_answer(input logic kind, input logic [KEY_W-1:0] key);
        answer_t ans;
        ans.kind = kind;
        ans.key = key;
        ans.found_key = '0;
        if (kind == KIND_INSERT)
        begin
            ans.status = table_insert(key);
            if (ans.status == STATUS_INSERTED)
                stored_keys.push_back(key);
        end
        else if (table_lookup(key))
        begin
            ans.status = STATUS_FOUND;
            ans.found_key = key;
        end
        else
            ans.status = STATUS_NOT_FOUND;
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    // Random burst and gap pacing on the input side.
    task automatic pace();
        int gap;
        if (!sender_idles)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 8);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, 12);
    endtask

    // Offer one beat and record its expected answer once accepted.
    task automatic send_beat(input logic kind, input logic [KEY_W-1:0] key);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, key};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        pending_answers.push_back(predict_answer(kind, key));
        beats_sent++;
        pace();
    endtask

    // Stop offering beats and wait until every answer has come back.
    task automatic drain_results(input int settle_cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_bucket_count(input logic [BC_W-1:0] value);
        drain_results(4);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        bucket_count = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'($urandom());
    endfunction

    function automatic logic [KEY_W-1:0] some_stored_key();
        if (stored_keys.size() == 0)
            return random_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Mostly searches, with hits, same-bucket misses and a trickle of inserts.
    task automatic send_random_beat();
        int pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 11)
        begin
            case ($urandom_range(0, 3))
                0: key = some_stored_key();
                1: key = KEY_W'($urandom_range(0, 40));
                default: key = random_key();
            endcase
            send_beat(KIND_INSERT, key);
        end
        else
        begin
            if (pick < 60)
                key = some_stored_key();
            else if (pick < 75)
                key = some_stored_key() + KEY_W'(hash_modulus() * $urandom_range(1, 3));
            else if (pick < 90)
                key = random_key();
            else
            begin
                case ($urandom_range(0, 2))
                    0: key = '0;
                    1: key = KEY_MAX;
                    default: key = KEY_W'($urandom_range(0, 20));
                endcase
            end
            send_beat(KIND_SEARCH, key);
        end
    endtask

    // Empty table, extreme keys, a shared bucket, duplicates and a found key of zero.
    task automatic test_basic_operations();
        send_beat(KIND_SEARCH, '0);
        send_beat(KIND_SEARCH, KEY_MAX);
        send_beat(KIND_INSERT, '0);
        send_beat(KIND_INSERT, KEY_MAX);
        send_beat(KIND_INSERT, KEY_W'(13));
        send_beat(KIND_INSERT, KEY_W'(26));
        send_beat(KIND_INSERT, KEY_W'(13));
        send_beat(KIND_SEARCH, '0);
        send_beat(KIND_SEARCH, KEY_W'(26));
        send_beat(KIND_SEARCH, KEY_MAX);
        send_beat(KIND_SEARCH, KEY_W'(39));
        send_beat(KIND_SEARCH, KEY_W'(1));
    endtask

    // One bucket, zero treated as one, saturation above the table size.
    task automatic test_bucket_count_edges();
        write_bucket_count(BC_W'(1));
        send_beat(KIND_INSERT, KEY_W'(5));
        send_beat(KIND_SEARCH, KEY_W'(5));
        send_beat(KIND_SEARCH, KEY_MAX);
        write_bucket_count(BC_W'(0));
        send_beat(KIND_SEARCH, KEY_W'(26));
        send_beat(KIND_SEARCH, KEY_W'(7));
        write_bucket_count(BC_W'(31));
        send_beat(KIND_INSERT, KEY_W'(31));
        send_beat(KIND_SEARCH, KEY_W'(31));
        write_bucket_count(BC_W'(16));
        send_beat(KIND_SEARCH, KEY_W'(47));
    endtask

    // Hold the output off for a long stretch while beats keep coming.
    task automatic test_output_backpressure();
        drain_results(4);
        sender_idles = 1'b0;
        long_hold_req = 1'b1;
        send_beat(KIND_INSERT, random_key());
        repeat (10) send_beat(KIND_SEARCH, some_stored_key());
        send_beat(KIND_INSERT, KEY_W'(100));
    endtask

    // Random traffic under several bucket counts, filling the pool on the way.
    task automatic test_random_traffic();
        logic [BC_W-1:0] counts [6];
        counts[0] = BC_W'(16);
        counts[1] = BC_W'(7);
        counts[2] = BC_W'(1);
        counts[3] = BC_W'(31);
        counts[4] = BC_W'($urandom_range(0, 31));
        counts[5] = BC_W'(2);
        foreach (counts[p])
        begin
            write_bucket_count(counts[p]);
            for (int i = 0; i < RANDOM_PHASE_BEATS; i++)
            begin
                if (i % 40 == 0)
                begin
                    sender_idles = ($urandom_range(0, 2) != 0);
                    burst_left = 0;
                end
                send_random_beat();
            end
        end
    endtask

    // Fill whatever is left of the pool, then check that inserts are dropped.
    task automatic test_pool_exhaustion();
        write_bucket_count(BUCKET_COUNT_RESET);
        sender_idles = 1'b1;
        while (nodes_used < POOL_NODES)
            send_beat(KIND_INSERT, random_key());
        send_beat(KIND_INSERT, '0);
        send_beat(KIND_INSERT, KEY_MAX);
        send_beat(KIND_SEARCH, some_stored_key());
        send_beat(KIND_SEARCH, KEY_W'(12345));
    endtask

    // Receiver: stall patterns of its own, plus a counted long hold on request.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int phase;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        phase = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ((phase % 5) < 2);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare every output beat with the oldest expected answer.
    always @(posedge clk)
    begin : check_results
        answer_t ans;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch($sformatf("output beat with nothing outstanding, status %0d",
                                          m_tuser));
            else
            begin
                ans = pending_answers.pop_front();
                if (m_tuser !== ans.status)
                    report_mismatch($sformatf("kind %0d key %0d: status %0d, expected %0d",
                                              ans.kind, ans.key, m_tuser, ans.status));
                if (m_tdata !== {1'b0, ans.found_key})
                    report_mismatch($sformatf("kind %0d key %0d: tdata %h, expected %h",
                                              ans.kind, ans.key, m_tdata,
                                              {1'b0, ans.found_key}));
                status_seen[ans.status]++;
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_INSERT;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        beats_sent = 0;
        cfg_writes = 0;
        sender_idles = 1'b1;
        burst_left = 0;
        long_hold_req = 1'b0;
        bucket_count = BUCKET_COUNT_RESET;
        nodes_used = 0;
        foreach (bucket_used[b])
            bucket_used[b] = 1'b0;
        foreach (status_seen[s])
            status_seen[s] = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_operations();
        test_bucket_count_edges();
        test_output_backpressure();
        test_random_traffic();
        test_pool_exhaustion();

        drain_results(200);

        $display("Covered %0d beats: %0d inserted, %0d found, %0d not found, %0d dropped",
                 beats_sent, status_seen[STATUS_INSERTED], status_seen[STATUS_FOUND],
                 status_seen[STATUS_NOT_FOUND], status_seen[STATUS_POOL_FULL]);
        $display("Bucket count written %0d times (0, 1, 2, 7, 13, 16, 31); pool %0d of %0d nodes",
                 cfg_writes, nodes_used, POOL_NODES);
        if (errors == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### chained_hash_table.f
sv/cht_pkg.sv
sv/cht_mod_unit.sv
sv/cht_node_ram.sv
sv/chained_hash_table.sv
tb/chained_hash_table_tb.sv
